FILE: hw/rtl/bbc_pkg.sv
// Shared types and constants for the bit-plane block complexity engine.
// No dependencies; every other file imports this package.
package bbc_pkg;

  localparam int unsigned SIDE    = 8;            // pixels per block side
  localparam int unsigned PIX_W   = 8;            // bits per pixel
  localparam int unsigned PLANES  = PIX_W;        // one plane per pixel bit
  localparam int unsigned ROW_W   = SIDE * PIX_W; // bits per block row
  localparam int unsigned CELLS   = SIDE * SIDE;  // bits per plane
  localparam int unsigned CNT_W   = 7;            // 0..112 border pairs

  localparam logic [CNT_W-1:0] THRESHOLD_RESET = 7'd34;

  typedef logic [ROW_W-1:0]           row_t;
  typedef logic [SIDE-1:0][ROW_W-1:0] rows_t;   // [i] is block row i
  typedef logic [CELLS-1:0]           plane_t;  // bit i*SIDE+j is pixel (i,j)
  typedef logic [PLANES-1:0][CELLS-1:0] planes_t;
  typedef logic [CNT_W-1:0]           count_t;
  typedef logic [PLANES-1:0][CNT_W-1:0] counts_t;

  // Count set bits of a byte.
  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] acc;
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      acc = acc + {3'b000, v[k]};
    end
    return acc;
  endfunction

endpackage

FILE: hw/rtl/bbc_pix_if.sv
// Input channel: one 8x8 block of 8-bit pixels as eight 64-bit rows per beat.
// Depends on bbc_pkg.
interface bbc_pix_if;
  import bbc_pkg::*;

  logic valid;
  logic ready;
  row_t row0;
  row_t row1;
  row_t row2;
  row_t row3;
  row_t row4;
  row_t row5;
  row_t row6;
  row_t row7;

  modport source(output valid, row0, row1, row2, row3, row4, row5, row6, row7,
                 input ready);
  modport sink(input valid, row0, row1, row2, row3, row4, row5, row6, row7,
               output ready);
endinterface

FILE: hw/rtl/bbc_res_if.sv
// Result channel: complexity mask and per-plane border counts per beat.
// Depends on bbc_pkg.
interface bbc_res_if;
  import bbc_pkg::*;

  logic               valid;
  logic               ready;
  logic [PLANES-1:0]  complex_mask;
  count_t             count_plane0;
  count_t             count_plane1;
  count_t             count_plane2;
  count_t             count_plane3;
  count_t             count_plane4;
  count_t             count_plane5;
  count_t             count_plane6;
  count_t             count_plane7;

  modport source(output valid, complex_mask, count_plane0, count_plane1,
                 count_plane2, count_plane3, count_plane4, count_plane5,
                 count_plane6, count_plane7,
                 input ready);
  modport sink(input valid, complex_mask, count_plane0, count_plane1,
               count_plane2, count_plane3, count_plane4, count_plane5,
               count_plane6, count_plane7,
               output ready);
endinterface

FILE: hw/rtl/bbc_gray_slice.sv
// Gray-codes every pixel of a block and slices the result into bit planes.
// Depends on bbc_pkg.
module bbc_gray_slice (
  input  bbc_pkg::rows_t   rows,
  output bbc_pkg::planes_t planes
);
  import bbc_pkg::*;

  // Gray bit p of a pixel is bit p xor bit p+1; the top bit passes as is.
  always_comb begin
    for (int p = 0; p < PLANES; p++) begin
      for (int i = 0; i < SIDE; i++) begin
        for (int j = 0; j < SIDE; j++) begin
          if (p == PLANES - 1) begin
            planes[p][i*SIDE + j] = rows[i][j*PIX_W + p];
          end else begin
            planes[p][i*SIDE + j] = rows[i][j*PIX_W + p] ^ rows[i][j*PIX_W + p + 1];
          end
        end
      end
    end
  end

endmodule

FILE: hw/rtl/bbc_plane_count.sv
// Counts differing neighbor pairs in one bit plane and compares to threshold.
// Depends on bbc_pkg.
module bbc_plane_count (
  input  bbc_pkg::plane_t plane,
  input  bbc_pkg::count_t thr,
  output bbc_pkg::count_t count,
  output logic            cplx
);
  import bbc_pkg::*;

  logic [SIDE-1:0][SIDE-1:0] hdiff;   // [i][j]: (i,j) vs (i,j+1), j < SIDE-1
  logic [SIDE-1:0][SIDE-1:0] vdiff;   // [i][j]: (i,j) vs (i+1,j), i < SIDE-1
  logic [SIDE-1:0][4:0]      row_cnt;
  logic [3:0][5:0]           sum2;
  logic [1:0][6:0]           sum4;

  // Mark borders; last column and last row have no neighbor beyond.
  always_comb begin
    hdiff = '0;
    vdiff = '0;
    for (int i = 0; i < SIDE; i++) begin
      for (int j = 0; j < SIDE - 1; j++) begin
        hdiff[i][j] = plane[i*SIDE + j] != plane[i*SIDE + j + 1];
      end
    end
    for (int i = 0; i < SIDE - 1; i++) begin
      for (int j = 0; j < SIDE; j++) begin
        vdiff[i][j] = plane[i*SIDE + j] != plane[(i+1)*SIDE + j];
      end
    end
  end

  // Sum per row, then a balanced adder tree over the rows.
  always_comb begin
    for (int i = 0; i < SIDE; i++) begin
      row_cnt[i] = {1'b0, pop8(hdiff[i])} + {1'b0, pop8(vdiff[i])};
    end
    for (int k = 0; k < 4; k++) begin
      sum2[k] = {1'b0, row_cnt[2*k]} + {1'b0, row_cnt[2*k + 1]};
    end
    for (int k = 0; k < 2; k++) begin
      sum4[k] = {1'b0, sum2[2*k]} + {1'b0, sum2[2*k + 1]};
    end
  end

  assign count = sum4[0] + sum4[1];
  assign cplx  = (count >= thr);

endmodule

FILE: hw/rtl/bitplane_block_complexity_core.sv
// Top level of the bit-plane block complexity engine.
// Depends on bbc_pkg, bbc_pix_if, bbc_res_if, bbc_gray_slice, bbc_plane_count.
//
// Usage:
//   pix  - valid/ready input channel, one 8x8 block (eight 64-bit rows) per
//          beat; pixel j of a row sits in bits 8j+7..8j.
//   res  - valid/ready output channel, one beat per input beat: the eight
//          Gray bit-plane border counts (0..112) and a mask with bit p set
//          when plane p's count is at least the threshold.
//   cfg_we/cfg_wdata - writes the 7-bit threshold; write only while idle.
// Path: the edge that accepts a block captures it in the input register;
//   the count/compare logic then feeds the result register, which loads
//   it at an edge where the result stage advances.
// Throughput: one block per cycle while res.ready stays high; the input
//   register and the result register each hold one beat, so the limit is
//   the per-cycle popcount tree between them.
// Reset: rst (synchronous) empties both stages and sets the threshold to 34.
// Stall: while res.ready is low the result holds; one more block is taken
//   into the input register, after which pix.ready drops until res drains.
module bitplane_block_complexity_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  bbc_pkg::count_t     cfg_wdata,
  bbc_pix_if.sink             pix,
  bbc_res_if.source           res
);
  import bbc_pkg::*;

  logic              pix_v;
  rows_t             rows_q;
  logic              res_v;
  counts_t           counts_q;
  logic [PLANES-1:0] mask_q;
  count_t            thr;

  logic              adv_res;
  planes_t           planes;
  counts_t           counts;
  logic [PLANES-1:0] mask;

  // Advance the result stage when it is empty or being taken.
  assign adv_res   = !res_v || res.ready;
  assign pix.ready = !pix_v || adv_res;

  // Control and threshold register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_v <= 1'b0;
      res_v <= 1'b0;
      thr   <= THRESHOLD_RESET;
    end else begin
      if (cfg_we) begin
        thr <= cfg_wdata;
      end
      if (pix.ready) begin
        pix_v <= pix.valid;
      end
      if (adv_res) begin
        res_v <= pix_v;
      end
    end
  end

  // Capture the incoming block.
  always_ff @(posedge clk) begin
    if (pix.valid && pix.ready) begin
      rows_q <= {pix.row7, pix.row6, pix.row5, pix.row4,
                 pix.row3, pix.row2, pix.row1, pix.row0};
    end
  end

  bbc_gray_slice u_slice (
    .rows   (rows_q),
    .planes (planes)
  );

  for (genvar p = 0; p < PLANES; p++) begin : g_plane
    bbc_plane_count u_count (
      .plane (planes[p]),
      .thr   (thr),
      .count (counts[p]),
      .cplx  (mask[p])
    );
  end

  // Load the result register.
  always_ff @(posedge clk) begin
    if (adv_res && pix_v) begin
      counts_q <= counts;
      mask_q   <= mask;
    end
  end

  assign res.valid        = res_v;
  assign res.complex_mask = mask_q;
  assign res.count_plane0 = counts_q[0];
  assign res.count_plane1 = counts_q[1];
  assign res.count_plane2 = counts_q[2];
  assign res.count_plane3 = counts_q[3];
  assign res.count_plane4 = counts_q[4];
  assign res.count_plane5 = counts_q[5];
  assign res.count_plane6 = counts_q[6];
  assign res.count_plane7 = counts_q[7];

endmodule
